FILE: hw/rtl/block_owner_map_allocator_defines.svh
// Assertion macros shared by the block owner map allocator RTL.
// Each macro expects signals named clk and rst_n in the including scope.
`ifndef BLOCK_OWNER_MAP_ALLOCATOR_DEFINES_SVH
`define BLOCK_OWNER_MAP_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is active
`define BOM_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active
`define BOM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/bom_pkg.sv
// Package for the block owner map allocator: command codes, state types,
// constants and the control structs between the sequencer and the map walker.
// No dependencies.
package bom_pkg;

    localparam int FUNC_W = 3;
    localparam int ID_W   = 8;
    localparam int BLK_W  = 9;
    localparam int SIZE_W = 16;
    localparam int RUN_W  = 10;
    localparam int SLOT_W = 2 * SIZE_W;

    localparam logic [ID_W-1:0]   FREE_MARK    = 8'hFF;
    localparam logic [SIZE_W-1:0] OFFSET_UNSET = 16'hFFFF;
    localparam logic [SIZE_W-1:0] SHRINK_LIMIT = 16'h0010;
    localparam logic [SIZE_W-1:0] SIZE_SHRUNK  = 16'h0001;
    localparam logic [SIZE_W-1:0] SIZE_EMPTY   = 16'h0000;
    localparam logic [RUN_W-1:0]  RUN_MAX      = 10'd1023;

    typedef enum logic [FUNC_W-1:0] {
        FN_LONGEST_RUN  = 3'd0,
        FN_FREE_OWNER   = 3'd1,
        FN_RELEASE_SLOT = 3'd2,
        FN_SHRINK_SLOT  = 3'd3,
        FN_WRITE_MAP    = 3'd4,
        FN_WRITE_SLOT   = 3'd5
    } func_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SLOT,
        ST_SCAN,
        ST_RESP
    } ctrl_state_t;

    typedef enum logic [1:0] {
        MP_CLEAR,
        MP_IDLE,
        MP_WALK
    } map_phase_t;

    // Sequencer to map walker
    typedef struct packed {
        logic            start;
        logic            free_en;
        logic [ID_W-1:0] id;
        logic            wr_en;
    } map_cmd_t;

    // Map walker to sequencer
    typedef struct packed {
        logic             ready;
        logic             done;
        logic             found;
        logic [RUN_W-1:0] run;
    } map_sts_t;

endpackage

FILE: hw/rtl/bom_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module bom_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write the addressed word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Register the read word
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

FILE: hw/rtl/bom_map_scan.sv
// Owner map walker: holds the owner map RAM, clears it after reset, takes
// single entry writes and walks all entries to free an owner and measure
// the longest free run. Depends on bom_pkg, bom_ram and the defines header.
`include "block_owner_map_allocator_defines.svh"

module bom_map_scan #(
    parameter int MAP_DEPTH = 512,
    localparam int AW = $clog2(MAP_DEPTH)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bom_pkg::map_cmd_t    cmd,
    input  logic [AW-1:0]        wr_addr,
    input  logic [bom_pkg::ID_W-1:0] wr_data,
    output bom_pkg::map_sts_t    sts
);

    import bom_pkg::*;

    localparam int CW = AW + 1;
    localparam logic [CW-1:0] CNT_END  = CW'(MAP_DEPTH);
    localparam logic [CW-1:0] CNT_LAST = CW'(MAP_DEPTH - 1);

    map_phase_t       phase_reg, phase_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             cmp_vld_reg, cmp_vld_next;
    logic [AW-1:0]    cmp_addr_reg;
    logic [ID_W-1:0]  id_reg;
    logic             free_en_reg;
    logic [RUN_W-1:0] cur_reg, cur_next;
    logic [RUN_W-1:0] best_reg, best_next;
    logic             found_reg, found_next;
    logic             issue;
    logic             walk_end;
    logic             hit;
    logic             start_now;
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [ID_W-1:0]  ram_wdata;
    logic [AW-1:0]    ram_raddr;
    logic [ID_W-1:0]  ram_rdata;

    bom_ram #(
        .WIDTH (ID_W),
        .DEPTH (MAP_DEPTH)
    ) u_map_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Walk status
    assign issue     = (phase_reg == MP_WALK) && (cnt_reg != CNT_END);
    assign walk_end  = (phase_reg == MP_WALK) && !issue && !cmp_vld_reg;
    assign hit       = cmp_vld_reg && free_en_reg && (ram_rdata == id_reg);
    assign start_now = (phase_reg == MP_IDLE) && cmd.start;
    assign ram_raddr = cnt_reg[AW-1:0];

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            MP_CLEAR:
            begin
                if (cnt_reg == CNT_LAST)
                begin
                    phase_next = MP_IDLE;
                end
            end
            MP_IDLE:
            begin
                if (cmd.start)
                begin
                    phase_next = MP_WALK;
                end
            end
            MP_WALK:
            begin
                if (walk_end)
                begin
                    phase_next = MP_IDLE;
                end
            end
            default:
            begin
                phase_next = MP_IDLE;
            end
        endcase
    end

    // Address counter and RAM write select
    always_comb
    begin
        cnt_next     = cnt_reg;
        cmp_vld_next = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = cnt_reg[AW-1:0];
        ram_wdata    = FREE_MARK;
        case (phase_reg)
            MP_CLEAR:
            begin
                ram_we   = 1'b1;
                cnt_next = (cnt_reg == CNT_LAST) ? '0 : cnt_reg + 1'b1;
            end
            MP_IDLE:
            begin
                ram_we    = cmd.wr_en;
                ram_waddr = wr_addr;
                ram_wdata = wr_data;
                cnt_next  = '0;
            end
            MP_WALK:
            begin
                ram_we       = hit;
                ram_waddr    = cmp_addr_reg;
                cmp_vld_next = issue;
                if (issue)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            default:
            begin
                cnt_next = '0;
            end
        endcase
    end

    // Track free runs and owner hits on each returned entry
    always_comb
    begin
        cur_next   = cur_reg;
        best_next  = best_reg;
        found_next = found_reg;
        if (start_now)
        begin
            cur_next   = '0;
            best_next  = '0;
            found_next = 1'b0;
        end
        else if (cmp_vld_reg)
        begin
            if (ram_rdata == FREE_MARK)
            begin
                cur_next = (cur_reg == RUN_MAX) ? RUN_MAX : cur_reg + 1'b1;
            end
            else
            begin
                cur_next = '0;
            end
            if (cur_next > best_reg)
            begin
                best_next = cur_next;
            end
            found_next = found_reg | hit;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= MP_CLEAR;
            cnt_reg     <= '0;
            cmp_vld_reg <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            cnt_reg     <= cnt_next;
            cmp_vld_reg <= cmp_vld_next;
        end
    end

    // Walk payload
    always_ff @(posedge clk)
    begin
        cmp_addr_reg <= cnt_reg[AW-1:0];
        cur_reg      <= cur_next;
        best_reg     <= best_next;
        found_reg    <= found_next;
        if (start_now)
        begin
            id_reg      <= cmd.id;
            free_en_reg <= cmd.free_en;
        end
    end

    assign sts.ready = (phase_reg == MP_IDLE);
    assign sts.done  = walk_end;
    assign sts.found = found_reg;
    assign sts.run   = best_reg;

    `BOM_ASSERT(a_walk_no_collide, (phase_reg == MP_WALK) && ram_we, ram_waddr != ram_raddr, "map write hits the entry being read")
    `BOM_ASSERT_NEXT(a_done_single, sts.done, !sts.done, "walk done held for more than one cycle")
    `BOM_ASSERT(a_clear_no_cmd, phase_reg == MP_CLEAR, !cmd.start && !cmd.wr_en, "command issued during map clear")

endmodule

FILE: hw/rtl/block_owner_map_allocator.sv
// Top level of the block owner map allocator: command sequencer, slot table
// RAM with per-slot valid bits, and the owner map walker.
// Depends on bom_pkg, bom_ram, bom_map_scan and the defines header.
//
// Usage: one command item enters on the cmd channel (cmd_valid/cmd_stall),
// and exactly one result item leaves on the rsp channel (rsp_valid/rsp_stall)
// carrying status and longest_free_run. One command is worked at a time.
// Path from accept to rsp_valid:
//   write map, write slot, bad id or unknown code: straight to the result
//   longest free run, free owner: through a full map walk
//   release / shrink slot: a slot read, then a map walk when blocks are freed
// The walk reads one map entry per cycle through the map RAM's single read
// port, freeing matches on the write port in the cycle after the read; that
// walk sets the cost of the scanning commands. A result waits in its register
// while rsp_stall is high and no new command is taken until it leaves.
// After reset the map RAM is swept to free, one entry per cycle, with
// cmd_stall high; the slot table reads as empty (size 0, offset unset) at
// once through its valid bits.
`include "block_owner_map_allocator_defines.svh"

module block_owner_map_allocator #(
    parameter int MAP_DEPTH  = 512,
    parameter int SLOT_COUNT = 96
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cmd_valid,
    output logic                       cmd_stall,
    input  logic [bom_pkg::FUNC_W-1:0] func,
    input  logic [bom_pkg::ID_W-1:0]   owner_id,
    input  logic [bom_pkg::BLK_W-1:0]  block_index,
    input  logic [bom_pkg::ID_W-1:0]   entry_value,
    input  logic [bom_pkg::SIZE_W-1:0] new_size,
    input  logic [bom_pkg::SIZE_W-1:0] new_offset,
    output logic                       rsp_valid,
    input  logic                       rsp_stall,
    output logic                       status,
    output logic [bom_pkg::RUN_W-1:0]  longest_free_run
);

    import bom_pkg::*;

    localparam int AW = $clog2(MAP_DEPTH);
    localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int XW = ((AW > BLK_W) ? AW : BLK_W) + 1;

    ctrl_state_t      state_reg, state_next;
    func_t            fn;
    func_t            func_reg;
    logic [ID_W-1:0]  id_reg;
    logic             status_reg, status_next;
    logic [RUN_W-1:0] run_reg, run_next;
    logic [SLOT_COUNT-1:0] slot_vld_reg;
    logic             accept;
    logic             id_ok;
    logic             idx_ok;
    logic [XW-1:0]    idx_wide;
    logic             slot_we;
    logic [SW-1:0]    slot_waddr;
    logic [SLOT_W-1:0] slot_wdata;
    logic [SLOT_W-1:0] slot_rdata;
    logic [SIZE_W-1:0] slot_size_cur;
    logic [SIZE_W-1:0] slot_off_cur;
    logic             slot_act;
    map_cmd_t         mcmd;
    map_sts_t         msts;

    bom_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (SLOT_COUNT)
    ) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .raddr (owner_id[SW-1:0]),
        .rdata (slot_rdata)
    );

    bom_map_scan #(
        .MAP_DEPTH (MAP_DEPTH)
    ) u_map_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (mcmd),
        .wr_addr (idx_wide[AW-1:0]),
        .wr_data (entry_value),
        .sts     (msts)
    );

    // Handshake and range checks
    assign fn        = func_t'(func);
    assign cmd_stall = !((state_reg == ST_IDLE) && msts.ready);
    assign accept    = cmd_valid && !cmd_stall;
    assign rsp_valid = (state_reg == ST_RESP);
    assign id_ok     = {1'b0, owner_id} < (ID_W + 1)'(SLOT_COUNT);
    assign idx_wide  = XW'(block_index);
    assign idx_ok    = idx_wide < XW'(MAP_DEPTH);

    // Slot entry as read; slots never written read as empty
    assign slot_size_cur = slot_vld_reg[id_reg[SW-1:0]] ? slot_rdata[SLOT_W-1:SIZE_W]
                                                        : SIZE_EMPTY;
    assign slot_off_cur  = slot_vld_reg[id_reg[SW-1:0]] ? slot_rdata[SIZE_W-1:0]
                                                        : OFFSET_UNSET;

    // Release acts on a set offset, shrink on a size over the limit
    always_comb
    begin
        if (func_reg == FN_RELEASE_SLOT)
        begin
            slot_act = (slot_off_cur != OFFSET_UNSET);
        end
        else
        begin
            slot_act = (slot_size_cur > SHRINK_LIMIT);
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (fn)
                        FN_LONGEST_RUN:
                        begin
                            state_next = ST_SCAN;
                        end
                        FN_FREE_OWNER:
                        begin
                            state_next = id_ok ? ST_SCAN : ST_RESP;
                        end
                        FN_RELEASE_SLOT, FN_SHRINK_SLOT:
                        begin
                            state_next = id_ok ? ST_SLOT : ST_RESP;
                        end
                        default:
                        begin
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end
            ST_SLOT:
            begin
                state_next = slot_act ? ST_SCAN : ST_RESP;
            end
            ST_SCAN:
            begin
                if (msts.done)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                if (!rsp_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Walker commands, slot writes and result values
    always_comb
    begin
        mcmd.start    = 1'b0;
        mcmd.free_en  = 1'b1;
        mcmd.id       = id_reg;
        mcmd.wr_en    = 1'b0;
        slot_we       = 1'b0;
        slot_waddr    = id_reg[SW-1:0];
        slot_wdata    = {SIZE_EMPTY, OFFSET_UNSET};
        status_next   = status_reg;
        run_next      = run_reg;
        case (state_reg)
            ST_IDLE:
            begin
                mcmd.id      = owner_id;
                mcmd.free_en = (fn != FN_LONGEST_RUN);
                slot_waddr   = owner_id[SW-1:0];
                slot_wdata   = {new_size, new_offset};
                if (accept)
                begin
                    run_next = '0;
                    case (fn)
                        FN_LONGEST_RUN:
                        begin
                            mcmd.start  = 1'b1;
                            status_next = 1'b0;
                        end
                        FN_FREE_OWNER:
                        begin
                            mcmd.start  = id_ok;
                            status_next = !id_ok;
                        end
                        FN_RELEASE_SLOT, FN_SHRINK_SLOT:
                        begin
                            status_next = !id_ok;
                        end
                        FN_WRITE_MAP:
                        begin
                            mcmd.wr_en  = idx_ok;
                            status_next = !idx_ok;
                        end
                        FN_WRITE_SLOT:
                        begin
                            slot_we     = id_ok;
                            status_next = !id_ok;
                        end
                        default:
                        begin
                            status_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_SLOT:
            begin
                mcmd.start  = slot_act;
                slot_we     = slot_act;
                status_next = 1'b0;
                if (func_reg == FN_RELEASE_SLOT)
                begin
                    slot_wdata = {SIZE_EMPTY, OFFSET_UNSET};
                end
                else
                begin
                    slot_wdata = {SIZE_SHRUNK, slot_off_cur};
                end
            end
            ST_SCAN:
            begin
                if (msts.done)
                begin
                    if (func_reg == FN_LONGEST_RUN)
                    begin
                        run_next    = msts.run;
                        status_next = 1'b0;
                    end
                    else if (func_reg == FN_FREE_OWNER)
                    begin
                        status_next = msts.found;
                    end
                    else
                    begin
                        status_next = 1'b0;
                    end
                end
            end
            default:
            begin
                status_next = status_reg;
            end
        endcase
    end

    // Control registers and slot valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            slot_vld_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (slot_we)
            begin
                slot_vld_reg[slot_waddr] <= 1'b1;
            end
        end
    end

    // Command and result payload
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        run_reg    <= run_next;
        if (accept)
        begin
            func_reg <= fn;
            id_reg   <= owner_id;
        end
    end

    assign status           = status_reg;
    assign longest_free_run = run_reg;

    `BOM_ASSERT(a_rsp_blocks_cmd, rsp_valid, cmd_stall, "command taken while a result is pending")
    `BOM_ASSERT(a_done_in_scan, msts.done, state_reg == ST_SCAN, "map walk ended outside the scan state")
    `BOM_ASSERT_NEXT(a_accept_leaves_idle, accept, state_reg != ST_IDLE, "accepted item did not leave idle")

endmodule
